FILE: sv/eslc_pkg.sv
// ----------------------------------------------------------------------------
// eslc_pkg
// Shared types and constants of the ELF32 segment load checker.
// ----------------------------------------------------------------------------
`default_nettype none

package eslc_pkg;

    localparam int unsigned PAGE_BYTES_DEF   = 4096;
    localparam logic [31:0] ALL_ONES         = 32'hFFFF_FFFF;
    localparam logic [24:0] MAX_IMAGE_BYTES  = 25'(16 * 1024 * 1024);

    localparam int unsigned CFG_ADDR_W = 5;

    typedef enum logic [2:0] {
        REG_IMAGE_SIZE  = 3'd0,
        REG_ENTRY_ADDR  = 3'd1,
        REG_USER_START  = 3'd2,
        REG_USER_TOP    = 3'd3,
        REG_BSS_LIMIT   = 3'd4
    } t_reg_idx;

    localparam logic [24:0] IMAGE_SIZE_RST  = 25'd0;
    localparam logic [31:0] ENTRY_ADDR_RST  = 32'd0;
    localparam logic [31:0] USER_START_RST  = 32'h0040_0000;
    localparam logic [31:0] USER_TOP_RST    = 32'hC000_0000;
    localparam logic [31:0] BSS_LIMIT_RST   = 32'(4 * 1024 * 1024);

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SKIPPED   = 3'd1,
        ST_BAD_FILE  = 3'd2,
        ST_BAD_RANGE = 3'd3,
        ST_BSS_OVER  = 3'd4,
        ST_NONE      = 3'd5,
        ST_BAD_ENTRY = 3'd6,
        ST_EARLIER   = 3'd7
    } t_status;

    typedef struct packed {
        logic [31:0] seg_type;
        logic [2:0]  seg_flags;
        logic [31:0] file_offset;
        logic [31:0] file_size;
        logic [31:0] mem_size;
        logic [31:0] virt_addr;
        logic        last;
    } t_seg_hdr;

    typedef struct packed {
        t_status     status;
        logic [31:0] load_base;
        logic [31:0] load_span;
        logic [31:0] zfill_base;
        logic [31:0] zfill_span;
        logic [31:0] code_base;
        logic [31:0] code_len;
        logic [31:0] rw_base;
        logic [31:0] rw_len;
        logic        done_res;
    } t_seg_res;

endpackage

`default_nettype wire

FILE: sv/eslc_hdr_if.sv
// ----------------------------------------------------------------------------
// eslc_hdr_if
// Valid/ready channel carrying one program header per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface eslc_hdr_if;
    logic               valid;
    logic               ready;
    eslc_pkg::t_seg_hdr data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/eslc_res_if.sv
// ----------------------------------------------------------------------------
// eslc_res_if
// Valid/ready channel carrying one check result per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface eslc_res_if;
    logic               valid;
    logic               ready;
    eslc_pkg::t_seg_res data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/elf_segment_load_checker_core.sv
// ----------------------------------------------------------------------------
// elf_segment_load_checker_core
// Checks ELF32 program headers and builds the load summary of one image.
//
//   channel   dir  handshake        payload
//   i_hdr     in   valid / ready    eslc_pkg::t_seg_hdr
//   o_res     out  valid / ready    eslc_pkg::t_seg_res
//   cfg       in   psel / penable   paddr, pwdata, prdata (APB, pready = 1)
//
// One header per cycle sustained while results are taken; a header is
// registered in the input stage at its transfer, and its result is then
// registered in the result stage.
// A stalled result holds a full input stage; header ready then drops.
// Reset (synchronous, active low) clears control state and registers.
// A header with last set clears the summary once its result is formed.
// ----------------------------------------------------------------------------
`default_nettype none

module elf_segment_load_checker_core #(
    parameter int unsigned PAGE_BYTES = eslc_pkg::PAGE_BYTES_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    eslc_hdr_if.sink                          i_hdr,
    eslc_res_if.source                        o_res,
    input  wire                               psel,
    input  wire                               penable,
    input  wire                               pwrite,
    input  wire  [eslc_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire  [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    localparam logic [31:0] PageLow  = 32'(PAGE_BYTES) - 32'd1;
    localparam logic [31:0] PageMask = ~PageLow;

    typedef struct packed {
        logic        last;
        logic        skip;
        logic        range_bad;
        logic        win_bad;
        logic        has_bss;
        logic        entry_in;
        logic        exec;
        logic        wr;
        logic [31:0] zlen;
        logic [31:0] zva;
        logic [31:0] end32;
        logic [31:0] va;
        logic [31:0] msz;
    } t_stage;

    // configuration
    logic [24:0] r_image_size;
    logic [31:0] r_entry_addr, r_user_start, r_user_top, r_bss_limit;
    logic        w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_size  <= eslc_pkg::IMAGE_SIZE_RST;
            r_entry_addr  <= eslc_pkg::ENTRY_ADDR_RST;
            r_user_start  <= eslc_pkg::USER_START_RST;
            r_user_top    <= eslc_pkg::USER_TOP_RST;
            r_bss_limit   <= eslc_pkg::BSS_LIMIT_RST;
        end else if (w_cfg_wr) begin
            unique case (paddr[4:2])
                eslc_pkg::REG_IMAGE_SIZE:  r_image_size  <= pwdata[24:0];
                eslc_pkg::REG_ENTRY_ADDR:  r_entry_addr  <= pwdata;
                eslc_pkg::REG_USER_START:  r_user_start  <= pwdata;
                eslc_pkg::REG_USER_TOP:    r_user_top    <= pwdata;
                eslc_pkg::REG_BSS_LIMIT:   r_bss_limit   <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            eslc_pkg::REG_IMAGE_SIZE:  prdata = {7'd0, r_image_size};
            eslc_pkg::REG_ENTRY_ADDR:  prdata = r_entry_addr;
            eslc_pkg::REG_USER_START:  prdata = r_user_start;
            eslc_pkg::REG_USER_TOP:    prdata = r_user_top;
            eslc_pkg::REG_BSS_LIMIT:   prdata = r_bss_limit;
            default:                   prdata = 32'd0;
        endcase
    end

    // input stage: per-header checks that need no summary state
    logic        r_in_valid, r_res_valid, w_adv;
    t_stage      r_in, n_in;
    logic [32:0] w_seg_end;
    logic [31:0] w_img32, w_span_lo, w_span_hi;

    assign w_adv       = r_in_valid && (!r_res_valid || o_res.ready);
    assign i_hdr.ready = !r_in_valid || w_adv;

    always_comb begin
        w_img32   = {7'd0, r_image_size};
        w_seg_end = {1'b0, i_hdr.data.virt_addr} + {1'b0, i_hdr.data.mem_size};
        w_span_lo = i_hdr.data.virt_addr & PageMask;
        w_span_hi = (w_seg_end[31:0] + PageLow) & PageMask;

        n_in.last      = i_hdr.data.last;
        n_in.skip      = (i_hdr.data.seg_type != 32'd1) || (i_hdr.data.mem_size == 32'd0);
        n_in.range_bad = (i_hdr.data.file_offset > w_img32)
                      || (i_hdr.data.file_size > (w_img32 - i_hdr.data.file_offset))
                      || (i_hdr.data.file_size > i_hdr.data.mem_size);
        n_in.win_bad   = (w_seg_end > {1'b0, r_user_top})
                      || (i_hdr.data.virt_addr < r_user_start)
                      || w_seg_end[32]
                      || (w_span_hi <= w_span_lo);
        n_in.has_bss   = i_hdr.data.mem_size > i_hdr.data.file_size;
        n_in.zlen      = i_hdr.data.mem_size - i_hdr.data.file_size;
        n_in.zva       = i_hdr.data.virt_addr + i_hdr.data.file_size;
        n_in.end32     = w_seg_end[31:0];
        n_in.va        = i_hdr.data.virt_addr;
        n_in.msz       = i_hdr.data.mem_size;
        n_in.entry_in  = (r_entry_addr >= i_hdr.data.virt_addr)
                      && (r_entry_addr < w_seg_end[31:0]);
        n_in.exec      = i_hdr.data.seg_flags[0];
        n_in.wr        = i_hdr.data.seg_flags[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_hdr.ready) begin
            r_in_valid <= i_hdr.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_hdr.valid && i_hdr.ready) begin
            r_in <= n_in;
        end
    end

    // result stage: summary state
    logic [31:0] r_base_addr, r_end_addr, r_bss_low, r_bss_high;
    logic [32:0] r_bss_total;
    logic [31:0] r_text_base, r_text_len, r_data_base, r_data_len;
    logic        r_any_loaded, r_entry_hit, r_entry_exec, r_failed;

    logic [31:0] n_base_addr, n_end_addr, n_bss_low, n_bss_high;
    logic [32:0] n_bss_total, w_bss_sum;
    logic [31:0] n_text_base, n_text_len, n_data_base, n_data_len;
    logic        n_any_loaded, n_entry_hit, n_entry_exec, n_failed;
    logic        w_img_bad, w_bss_over, w_loaded;
    eslc_pkg::t_status w_status;
    eslc_pkg::t_seg_res n_res, r_res;

    always_comb begin
        n_base_addr  = r_base_addr;
        n_end_addr   = r_end_addr;
        n_bss_low    = r_bss_low;
        n_bss_high   = r_bss_high;
        n_bss_total  = r_bss_total;
        n_text_base  = r_text_base;
        n_text_len   = r_text_len;
        n_data_base  = r_data_base;
        n_data_len   = r_data_len;
        n_any_loaded = r_any_loaded;
        n_entry_hit  = r_entry_hit;
        n_entry_exec = r_entry_exec;
        n_failed     = r_failed;

        w_img_bad  = (r_image_size == 25'd0) || (r_image_size > eslc_pkg::MAX_IMAGE_BYTES);
        w_bss_sum  = r_bss_total + {1'b0, r_in.zlen};
        w_bss_over = w_bss_sum > {1'b0, r_bss_limit};

        if (r_failed) begin
            w_status = eslc_pkg::ST_EARLIER;
        end else if (w_img_bad) begin
            w_status = eslc_pkg::ST_BAD_FILE;
            n_failed = 1'b1;
        end else if (r_in.skip) begin
            w_status = eslc_pkg::ST_SKIPPED;
        end else if (r_in.range_bad) begin
            w_status = eslc_pkg::ST_BAD_FILE;
            n_failed = 1'b1;
        end else if (r_in.win_bad) begin
            w_status = eslc_pkg::ST_BAD_RANGE;
            n_failed = 1'b1;
        end else if (r_in.has_bss && w_bss_over) begin
            w_status    = eslc_pkg::ST_BSS_OVER;
            n_failed    = 1'b1;
            n_bss_total = w_bss_sum;
        end else begin
            w_status = eslc_pkg::ST_OK;
            if (r_in.has_bss) begin
                n_bss_total = w_bss_sum;
                if (r_in.zva < r_bss_low) begin
                    n_bss_low = r_in.zva;
                end
                if (r_in.end32 > r_bss_high) begin
                    n_bss_high = r_in.end32;
                end
            end
            if (r_in.entry_in) begin
                n_entry_hit = 1'b1;
                if (r_in.exec) begin
                    n_entry_exec = 1'b1;
                end
            end
            if (r_in.va < r_base_addr) begin
                n_base_addr = r_in.va;
            end
            if (r_in.end32 > r_end_addr) begin
                n_end_addr = r_in.end32;
            end
            if (r_in.exec && (r_text_len == 32'd0)) begin
                n_text_base = r_in.va;
                n_text_len  = r_in.msz;
            end
            if (r_in.wr && !r_in.exec && (r_data_len == 32'd0)) begin
                n_data_base = r_in.va;
                n_data_len  = r_in.msz;
            end
            n_any_loaded = 1'b1;
        end

        w_loaded = n_any_loaded && (n_base_addr != eslc_pkg::ALL_ONES);
        if (r_in.last && !n_failed) begin
            if (!w_loaded) begin
                w_status = eslc_pkg::ST_NONE;
            end else if (!n_entry_hit || !n_entry_exec) begin
                w_status = eslc_pkg::ST_BAD_ENTRY;
            end
        end

        n_res.status    = w_status;
        n_res.load_base = w_loaded ? n_base_addr : 32'd0;
        n_res.load_span = w_loaded ? (n_end_addr - n_base_addr) : 32'd0;
        if (n_bss_low != eslc_pkg::ALL_ONES) begin
            n_res.zfill_base = n_bss_low;
            n_res.zfill_span = n_bss_high - n_bss_low;
        end else begin
            n_res.zfill_base = 32'd0;
            n_res.zfill_span = 32'd0;
        end
        n_res.code_base = n_text_base;
        n_res.code_len  = n_text_len;
        n_res.rw_base   = n_data_base;
        n_res.rw_len    = n_data_len;
        n_res.done_res  = r_in.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_adv && r_in.last)) begin
            r_base_addr  <= eslc_pkg::ALL_ONES;
            r_end_addr   <= 32'd0;
            r_bss_low    <= eslc_pkg::ALL_ONES;
            r_bss_high   <= 32'd0;
            r_bss_total  <= 33'd0;
            r_text_base  <= 32'd0;
            r_text_len   <= 32'd0;
            r_data_base  <= 32'd0;
            r_data_len   <= 32'd0;
            r_any_loaded <= 1'b0;
            r_entry_hit  <= 1'b0;
            r_entry_exec <= 1'b0;
            r_failed     <= 1'b0;
        end else if (w_adv) begin
            r_base_addr  <= n_base_addr;
            r_end_addr   <= n_end_addr;
            r_bss_low    <= n_bss_low;
            r_bss_high   <= n_bss_high;
            r_bss_total  <= n_bss_total;
            r_text_base  <= n_text_base;
            r_text_len   <= n_text_len;
            r_data_base  <= n_data_base;
            r_data_len   <= n_data_len;
            r_any_loaded <= n_any_loaded;
            r_entry_hit  <= n_entry_hit;
            r_entry_exec <= n_entry_exec;
            r_failed     <= n_failed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (w_adv) begin
            r_res_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid = r_res_valid;
    assign o_res.data  = r_res;

    // checks
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in.last) |=> (!r_failed && !r_any_loaded && (r_bss_total == 33'd0)))
        else $error("summary not cleared after last header");

    a_sticky_failure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_failed) |-> (n_res.status == eslc_pkg::ST_EARLIER))
        else $error("failed state did not force earlier-failure status");

    a_loaded_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_any_loaded |-> (r_base_addr != eslc_pkg::ALL_ONES))
        else $error("segment loaded but base address unset");

    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_res_valid && !o_res.ready) |=> (r_in_valid && $stable(r_in)))
        else $error("input stage lost a header while output stalled");

    a_ok_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && !r_in.last && (n_res.status == eslc_pkg::ST_OK)) |=> r_any_loaded)
        else $error("ok status without a loaded segment");

endmodule

`default_nettype wire

FILE: tb/eslc_board_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eslc_board_pkg
// Load summary predictor and result scoreboard for the segment load checker.
// Keeps its own register copy and summary state, works out the result of each
// accepted program header and checks DUT results in order against them.
// ----------------------------------------------------------------------------
`default_nettype none

package eslc_board_pkg;

    import eslc_pkg::*;

    class load_summary_board;
        logic [24:0] image_size;
        logic [31:0] entry_addr;
        logic [31:0] user_start;
        logic [31:0] user_top;
        logic [31:0] bss_limit;

        logic [31:0] base_addr;
        logic [31:0] end_addr;
        logic [31:0] bss_low;
        logic [31:0] bss_high;
        logic [32:0] bss_total;
        logic [31:0] text_base;
        logic [31:0] text_len;
        logic [31:0] data_base;
        logic [31:0] data_len;
        logic        any_loaded;
        logic        entry_hit;
        logic        entry_exec;
        logic        failed;

        t_seg_res    expected_summaries[$];
        int unsigned mismatches;

        function new();
            image_size  = IMAGE_SIZE_RST;
            entry_addr  = ENTRY_ADDR_RST;
            user_start  = USER_START_RST;
            user_top    = USER_TOP_RST;
            bss_limit   = BSS_LIMIT_RST;
            mismatches  = 0;
            clear_summary();
        endfunction

        function void clear_summary();
            base_addr  = ALL_ONES;
            end_addr   = '0;
            bss_low    = ALL_ONES;
            bss_high   = '0;
            bss_total  = '0;
            text_base  = '0;
            text_len   = '0;
            data_base  = '0;
            data_len   = '0;
            any_loaded = 1'b0;
            entry_hit  = 1'b0;
            entry_exec = 1'b0;
            failed     = 1'b0;
        endfunction

        function void set_register(t_reg_idx idx, logic [31:0] value);
            case (idx)
                REG_IMAGE_SIZE:  image_size  = value[24:0];
                REG_ENTRY_ADDR:  entry_addr  = value;
                REG_USER_START:  user_start  = value;
                REG_USER_TOP:    user_top    = value;
                REG_BSS_LIMIT:   bss_limit   = value;
                default: ;
            endcase
        endfunction

        function void note_header(t_seg_hdr h);
            t_status     st;
            t_seg_res    r;
            logic [32:0] seg_end;
            logic [31:0] end32;
            logic [31:0] page_m1;
            logic [31:0] span_lo;
            logic [31:0] span_hi;
            logic [31:0] zlen;
            logic [31:0] zva;
            logic        loaded;

            page_m1 = PAGE_BYTES_DEF - 1;
            seg_end = {1'b0, h.virt_addr} + {1'b0, h.mem_size};
            end32   = seg_end[31:0];
            span_lo = h.virt_addr & ~page_m1;
            span_hi = (end32 + page_m1) & ~page_m1;
            zlen    = h.mem_size - h.file_size;
            zva     = h.virt_addr + h.file_size;
            st      = ST_OK;

            if (failed) begin
                st = ST_EARLIER;
            end else if (image_size == '0 || image_size > MAX_IMAGE_BYTES) begin
                st     = ST_BAD_FILE;
                failed = 1'b1;
            end else if (h.seg_type != 32'd1 || h.mem_size == '0) begin
                st = ST_SKIPPED;
            end else begin
                if (h.file_offset > image_size || h.file_size > image_size - h.file_offset
                        || h.file_size > h.mem_size) begin
                    st = ST_BAD_FILE;
                end else if (seg_end > {1'b0, user_top} || h.virt_addr < user_start
                        || seg_end[32] || span_hi <= span_lo) begin
                    st = ST_BAD_RANGE;
                end else begin
                    if (h.mem_size > h.file_size) begin
                        bss_total = bss_total + zlen;
                        if (bss_total > {1'b0, bss_limit}) begin
                            st = ST_BSS_OVER;
                        end else begin
                            if (zva < bss_low) bss_low = zva;
                            if (end32 > bss_high) bss_high = end32;
                        end
                    end
                    if (st == ST_OK) begin
                        if (entry_addr >= h.virt_addr && entry_addr < end32) begin
                            entry_hit = 1'b1;
                            if (h.seg_flags[0]) entry_exec = 1'b1;
                        end
                        if (h.virt_addr < base_addr) base_addr = h.virt_addr;
                        if (end32 > end_addr) end_addr = end32;
                        if (h.seg_flags[0] && text_len == '0) begin
                            text_base = h.virt_addr;
                            text_len  = h.mem_size;
                        end
                        if (h.seg_flags[1] && !h.seg_flags[0] && data_len == '0) begin
                            data_base = h.virt_addr;
                            data_len  = h.mem_size;
                        end
                        any_loaded = 1'b1;
                    end
                end
                if (st != ST_OK) failed = 1'b1;
            end

            if (h.last && !failed) begin
                if (!any_loaded || base_addr == ALL_ONES) begin
                    st = ST_NONE;
                end else if (!entry_hit || !entry_exec) begin
                    st = ST_BAD_ENTRY;
                end
            end

            loaded       = any_loaded && base_addr != ALL_ONES;
            r.status     = st;
            r.load_base  = loaded ? base_addr : '0;
            r.load_span  = loaded ? end_addr - base_addr : '0;
            r.zfill_base = (bss_low != ALL_ONES) ? bss_low : '0;
            r.zfill_span = (bss_low != ALL_ONES) ? bss_high - bss_low : '0;
            r.code_base  = text_base;
            r.code_len   = text_len;
            r.rw_base    = data_base;
            r.rw_len     = data_len;
            r.done_res   = h.last;
            expected_summaries.push_back(r);

            if (h.last) clear_summary();
        endfunction

        function string show(t_seg_res r);
            return $sformatf({"st=%0d base=%h size=%h bss=%h/%h text=%h/%h ",
                              "data=%h/%h done=%b"},
                             r.status, r.load_base, r.load_span, r.zfill_base,
                             r.zfill_span, r.code_base, r.code_len, r.rw_base,
                             r.rw_len, r.done_res);
        endfunction

        function void check_result(t_seg_res got);
            t_seg_res want;

            if (expected_summaries.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: result with nothing pending: %s", $time, show(got));
                end
                return;
            end
            want = expected_summaries.pop_front();
            if (got.status !== want.status || got.load_base !== want.load_base
                    || got.load_span !== want.load_span
                    || got.zfill_base !== want.zfill_base
                    || got.zfill_span !== want.zfill_span
                    || got.code_base !== want.code_base
                    || got.code_len !== want.code_len
                    || got.rw_base !== want.rw_base
                    || got.rw_len !== want.rw_len
                    || got.done_res !== want.done_res) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: result mismatch", $time);
                    $display("  expected %s", show(want));
                    $display("  actual   %s", show(got));
                end
            end
        endfunction
    endclass

endpackage

`default_nettype wire

FILE: tb/tb_elf_segment_load_checker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_elf_segment_load_checker_core
// Testbench of the ELF32 segment load checker.
// Runs directed program headers for every status and corner of the checks,
// then random images of mostly well-formed segments with noise, over several
// register settings, with random gaps on the header side and random stalls
// on the result side. Every result is checked against the predicted summary.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_elf_segment_load_checker_core;

    import eslc_pkg::*;
    import eslc_board_pkg::*;

    localparam int unsigned PHASE_ITEMS   = 198;
    localparam int unsigned INVALID_ITEMS = 40;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    eslc_hdr_if hdr_if ();
    eslc_res_if res_if ();

    load_summary_board board;
    int unsigned       sent_count;
    int unsigned       hdr_gap_pct;
    int unsigned       res_stall_pct;
    int unsigned       res_hold;

    elf_segment_load_checker_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_hdr   (hdr_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("Some tests failed");
        $finish;
    end

    always @(posedge i_clk) begin
        if (res_hold != 0) begin
            res_if.ready <= 1'b0;
            res_hold = res_hold - 1;
        end else if (res_stall_pct != 0 && $urandom_range(99) < res_stall_pct) begin
            res_if.ready <= 1'b0;
            res_hold = $urandom_range(17, 0);
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            board.check_result(res_if.data);
        end
    end

    function automatic t_seg_hdr mk_hdr(input logic [31:0] typ, input logic [2:0] flags,
                                        input logic [31:0] off, input logic [31:0] fsz,
                                        input logic [31:0] msz, input logic [31:0] va,
                                        input logic last);
        t_seg_hdr h;
        h.seg_type    = typ;
        h.seg_flags   = flags;
        h.file_offset = off;
        h.file_size   = fsz;
        h.mem_size    = msz;
        h.virt_addr   = va;
        h.last        = last;
        return h;
    endfunction

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        board.set_register(idx, value);
    endtask

    task automatic configure(input logic [31:0] img, input logic [31:0] ent,
                             input logic [31:0] ust, input logic [31:0] utop,
                             input logic [31:0] blim);
        write_reg(REG_IMAGE_SIZE, img);
        write_reg(REG_ENTRY_ADDR, ent);
        write_reg(REG_USER_START, ust);
        write_reg(REG_USER_TOP, utop);
        write_reg(REG_BSS_LIMIT, blim);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_header(input t_seg_hdr h);
        if (hdr_gap_pct != 0 && $urandom_range(99) < hdr_gap_pct) begin
            hdr_if.valid <= 1'b0;
            repeat ($urandom_range(18, 1)) @(posedge i_clk);
        end
        hdr_if.valid <= 1'b1;
        hdr_if.data  <= h;
        do @(posedge i_clk); while (!hdr_if.ready);
        board.note_header(h);
        sent_count++;
    endtask

    // hold off until every pending summary has been checked
    task automatic drain();
        hdr_if.valid <= 1'b0;
        while (board.expected_summaries.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic send_image(input int unsigned nseg);
        t_seg_hdr    h;
        logic [31:0] cursor;
        logic [31:0] zlen;
        int unsigned pick;

        cursor = board.user_start;
        for (int unsigned i = 0; i < nseg; i++) begin
            pick        = $urandom_range(99);
            h.seg_type  = 32'd1;
            h.seg_flags = (i == 0 && pick < 90) ? (3'($urandom) | 3'b001) : 3'($urandom);
            h.file_size = $urandom_range(32'h3000, 0);
            if (h.file_size > board.image_size) h.file_size = board.image_size;
            h.file_offset = $urandom_range(board.image_size - h.file_size, 0);
            zlen          = ($urandom_range(2) == 0) ? $urandom_range(32'h2000, 1) : 32'd0;
            h.mem_size    = h.file_size + zlen;
            if (i == 0) begin
                h.virt_addr = board.user_start;
                if (h.mem_size < 32'h2000) h.mem_size = 32'h2000;
            end else begin
                h.virt_addr = cursor + $urandom_range(32'hFFF, 0);
            end
            if (h.mem_size == '0) h.mem_size = 32'd1;
            cursor = ((h.virt_addr + h.mem_size + 32'hFFF) & ~32'hFFF)
                     + ($urandom_range(3) << 12);
            h.last = (i == nseg - 1);

            if (pick < 6) begin
                h.seg_type = $urandom;
            end else if (pick < 10) begin
                h.mem_size = '0;
            end else if (pick < 14) begin
                h.seg_type    = $urandom_range(1) ? 32'd1 : $urandom;
                h.file_offset = $urandom;
                h.file_size   = $urandom;
                h.mem_size    = $urandom;
                h.virt_addr   = $urandom;
            end else if (pick < 18) begin
                case ($urandom_range(3))
                    0:       h.file_size   = h.mem_size + 1;
                    1:       h.file_offset = board.image_size + 1;
                    2:       h.virt_addr   = board.user_start - 1;
                    default: h.virt_addr   = board.user_top - 32'h10;
                endcase
            end
            send_header(h);
        end
    endtask

    initial begin
        logic [31:0] img;
        logic [31:0] ent;
        logic [31:0] ust;
        logic [31:0] utop;
        logic [31:0] blim;
        int unsigned phase_end;

        board         = new();
        sent_count    = 0;
        hdr_if.valid <= 1'b0;
        hdr_if.data  <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        i_rst_n      <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n      <= 1'b1;

        hdr_gap_pct   = 20;
        res_stall_pct = 20;

        // image size still zero after reset
        send_header(mk_hdr(32'd1, 3'b101, 32'd0, 32'h100, 32'h100, 32'h0040_0000, 1'b0));
        send_header(mk_hdr(32'd1, 3'b101, 32'd0, 32'h100, 32'h100, 32'h0040_0000, 1'b1));
        drain();

        configure(32'(MAX_IMAGE_BYTES), 32'h0040_1000, 32'h0040_0000, 32'hC000_0000,
                  32'h0040_0000);
        send_header(mk_hdr(32'd6, 3'b100, 32'h34, 32'h100, 32'h100, 32'h0040_0040, 1'b0));
        send_header(mk_hdr(32'd1, 3'b110, 32'd0, 32'd0, 32'd0, 32'h0050_0000, 1'b0));
        send_header(mk_hdr(32'd1, 3'b101, 32'd0, 32'h2000, 32'h2000, 32'h0040_0000, 1'b0));
        send_header(mk_hdr(32'd1, 3'b110, 32'h2000, 32'h1000, 32'h3000, 32'h0040_2000,
                           1'b0));
        send_header(mk_hdr(32'd4, 3'b100, 32'h3000, 32'h20, 32'h20, 32'd0, 1'b1));
        send_header(mk_hdr(32'd0, 3'b000, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1));
        send_header(mk_hdr(32'd1, 3'b110, 32'd0, 32'h2000, 32'h2000, 32'h0040_0000, 1'b1));
        send_header(mk_hdr(32'd1, 3'b101, 32'h0100_0001, 32'h10, 32'h10, 32'h0040_0000,
                           1'b0));
        send_header(mk_hdr(32'd1, 3'b101, 32'd0, 32'h10, 32'h10, 32'h0040_0000, 1'b0));
        send_header(mk_hdr(32'd1, 3'b101, 32'd0, 32'h10, 32'h10, 32'h0040_0000, 1'b1));
        send_header(mk_hdr(32'd1, 3'b101, 32'd0, 32'h20, 32'h10, 32'h0040_0000, 1'b1));
        send_header(mk_hdr(32'd1, 3'b101, 32'd0, 32'h10, 32'h10, 32'h003F_F000, 1'b1));
        send_header(mk_hdr(32'd1, 3'b101, 32'd0, 32'h10, 32'h2000, 32'hBFFF_F000, 1'b1));
        send_header(mk_hdr(32'd1, 3'b101, 32'd0, 32'h1000, 32'h1000, 32'h0040_0000, 1'b0));
        send_header(mk_hdr(32'd1, 3'b110, 32'd0, 32'd0, 32'h0040_0001, 32'h0050_0000,
                           1'b1));
        drain();

        configure(32'd1, ALL_ONES, 32'd0, ALL_ONES, 32'd0);
        send_header(mk_hdr(32'd1, 3'b111, 32'd0, 32'd0, 32'h100, 32'hFFFF_F800, 1'b1));
        send_header(mk_hdr(32'd1, 3'b001, 32'd0, 32'd1, 32'd1, 32'hFFFF_E000, 1'b1));
        send_header(mk_hdr(32'd1, 3'b001, 32'd1, 32'd0, 32'h10, 32'd0, 1'b1));
        send_header(mk_hdr(ALL_ONES, 3'b111, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 1'b1));
        send_header(mk_hdr(32'd1, 3'b111, ALL_ONES, 32'd0, 32'd1, 32'd0, 1'b1));
        send_header(mk_hdr(32'd1, 3'b000, 32'd0, 32'd1, 32'd1, ALL_ONES, 1'b1));
        drain();

        configure(32'h01FF_FFFF, ALL_ONES, 32'd0, ALL_ONES, 32'd0);
        send_header(mk_hdr(32'd1, 3'b101, 32'd0, 32'h10, 32'h10, 32'h0040_0000, 1'b1));
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            ust  = (ph == 0) ? 32'd0 : $urandom_range(32'h4000_0000, 32'h1000);
            utop = (ph == 0 || ph == 5) ? ALL_ONES
                                        : ust + $urandom_range(32'h1000_0000, 32'h10_0000);
            ent  = (ph == 3) ? ALL_ONES : ust + $urandom_range(32'h1FFF, 0);
            if (ph == 0) begin
                img = 32'(MAX_IMAGE_BYTES);
            end else if (ph == 1) begin
                img = $urandom_range(32'h1000, 1);
            end else if (ph == 4) begin
                img = $urandom_range(32'h01FF_FFFF, 32'(MAX_IMAGE_BYTES) + 1);
            end else begin
                img = $urandom_range(32'(MAX_IMAGE_BYTES), 1);
            end
            if (ph == 0) begin
                blim = ALL_ONES;
            end else if (ph == 1) begin
                blim = $urandom_range(32'h4000, 0);
            end else begin
                blim = $urandom_range(32'h0080_0000, 32'h8000);
            end
            configure(img, ent, ust, utop, blim);

            if (ph == 7) begin
                hdr_gap_pct   = 0;
                res_stall_pct = 0;
            end else begin
                hdr_gap_pct   = ($urandom_range(2) == 0) ? 0 : $urandom_range(35, 5);
                res_stall_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(35, 5);
            end

            phase_end = sent_count + ((ph == 4) ? INVALID_ITEMS : PHASE_ITEMS);
            while (sent_count < phase_end) send_image($urandom_range(8, 1));
            drain();
        end

        if (board.mismatches == 0 && board.expected_summaries.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
